// ===== rtl/core/mqfm_pkg.sv =====
`default_nettype none

package mqfm_pkg;

  localparam int NUM_QUEUES_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_WIDTH_DEF    = 16;

  localparam logic [3:0]  QUEUES_RESET = 4'd8;
  localparam logic [15:0] SERVED_MAX   = 16'hFFFF;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    op_t         operation;
    logic [2:0]  queue_index;
    logic [15:0] item_id;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] item_out;
    logic [4:0]  queue_count;
    logic [15:0] served_total;
    logic [7:0]  waiting_total;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/multi_queue_fifo_manager_core.sv =====
`default_nettype none

// Several FIFO queues of item ids, each a fixed ring in one shared store.
// Command channel: an item (operation, queue_index, item_id) is transferred at
// a rising edge where start is high and busy is low. Busy is high only while
// rst is asserted, so an item may be issued in every cycle.
// Result channel: done is high for exactly one cycle together with result;
// the receiver cannot stall it. Each item gives one result, in order, after
// it has passed the s1 and s2 registers. Throughput is one item per cycle:
// each item reads and updates one queue's head and count registers in a single
// stage and touches one word of the store, whose dequeue read is registered.
// The count, served and waiting figures in a result are those after its step.
// Configuration: cfg_write with cfg_data sets queues_in_use; write it only
// while no item is in flight.
// Reset: head pointers, counts, the served and waiting counters and the
// pipeline valid bits are cleared, queues_in_use returns to 8. The store is
// not cleared; the ring discipline never reads an unwritten word.
module multi_queue_fifo_manager_core #(
  parameter int NUM_QUEUES  = mqfm_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqfm_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = mqfm_pkg::ID_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire mqfm_pkg::item_t  item,
  output logic                  done,
  output mqfm_pkg::result_t     result,
  input  wire logic             cfg_write,
  input  wire logic [3:0]       cfg_data
);

  localparam int QIW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW    = $clog2(DEPTH + 1);

  logic [ID_WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]       head_pointer [NUM_QUEUES];
  logic [CW-1:0]       entry_count [NUM_QUEUES];
  logic [15:0]         served;
  logic [WW-1:0]       waiting;
  logic [3:0]          queues_in_use;

  logic                s1_valid;
  mqfm_pkg::item_t     s1;
  logic                s2_valid;
  mqfm_pkg::status_t   s2_status;
  logic [4:0]          s2_count;
  logic                s2_deq;
  logic [ID_WIDTH-1:0] rd_data;

  logic [QIW-1:0]      qi;
  logic                valid_q;
  logic [PW-1:0]       hd;
  logic [CW-1:0]       cnt;
  logic [PW:0]         tail_sum;
  logic [PW:0]         head_sum;
  logic [PW-1:0]       tail;
  logic [PW-1:0]       head_next;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  mqfm_pkg::status_t   status_next;
  logic [CW-1:0]       count_next;
  logic                enq_do;
  logic                deq_do;

  assign busy = rst;

  always_comb begin
    qi      = QIW'(s1.queue_index);
    valid_q = ({1'b0, s1.queue_index} < queues_in_use) &&
              (int'(s1.queue_index) < NUM_QUEUES);
    hd      = head_pointer[qi];
    cnt     = entry_count[qi];

    tail_sum  = (PW+1)'(hd) + (PW+1)'(cnt);
    tail      = (tail_sum >= (PW+1)'(QUEUE_DEPTH)) ?
                PW'(tail_sum - (PW+1)'(QUEUE_DEPTH)) : PW'(tail_sum);
    head_sum  = (PW+1)'(hd) + (PW+1)'(1);
    head_next = (head_sum >= (PW+1)'(QUEUE_DEPTH)) ?
                PW'(head_sum - (PW+1)'(QUEUE_DEPTH)) : PW'(head_sum);
    waddr     = AW'(int'(qi) * QUEUE_DEPTH + int'(tail));
    raddr     = AW'(int'(qi) * QUEUE_DEPTH + int'(hd));

    status_next = mqfm_pkg::ST_OK;
    count_next  = cnt;
    enq_do      = 1'b0;
    deq_do      = 1'b0;
    priority if (!valid_q) begin
      status_next = mqfm_pkg::ST_INVALID;
      count_next  = '0;
    end else if (s1.operation == mqfm_pkg::OP_ENQUEUE) begin
      if (cnt == CW'(QUEUE_DEPTH)) begin
        status_next = mqfm_pkg::ST_FULL;
      end else begin
        enq_do     = s1_valid;
        count_next = cnt + CW'(1);
      end
    end else begin
      if (cnt == '0) begin
        status_next = mqfm_pkg::ST_EMPTY;
      end else begin
        deq_do     = s1_valid;
        count_next = cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      served        <= '0;
      waiting       <= '0;
      queues_in_use <= mqfm_pkg::QUEUES_RESET;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_pointer[i] <= '0;
        entry_count[i]  <= '0;
      end
    end else begin
      s1_valid <= start && !busy;
      s2_valid <= s1_valid;
      if (cfg_write) begin
        queues_in_use <= cfg_data;
      end
      if (enq_do) begin
        entry_count[qi] <= count_next;
        waiting         <= waiting + WW'(1);
      end
      if (deq_do) begin
        entry_count[qi]  <= count_next;
        head_pointer[qi] <= head_next;
        waiting          <= waiting - WW'(1);
        if (served != mqfm_pkg::SERVED_MAX) begin
          served <= served + 16'd1;
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1 <= item;
    end
    s2_status <= status_next;
    s2_count  <= 5'(count_next);
    s2_deq    <= deq_do;
  end

  always_ff @(posedge clk) begin
    if (enq_do) begin
      store[waddr] <= ID_WIDTH'(s1.item_id);
    end
    if (deq_do) begin
      rd_data <= store[raddr];
    end
  end

  // The served and waiting counters already hold the values after the item
  // now in the result stage, since the next item updates them at this edge.
  always_comb begin
    done                 = s2_valid;
    result.status        = s2_status;
    result.item_out      = s2_deq ? 16'(rd_data) : 16'd0;
    result.queue_count   = s2_count;
    result.served_total  = served;
    result.waiting_total = 8'(waiting);
  end

endmodule

`default_nettype wire

// ===== rtl/core/mqfm_checker.sv =====
`default_nettype none

module mqfm_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire mqfm_pkg::result_t result
);

  // Every transfer yields its result strobe on done.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result missing two cycles after a command transfer");

  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a matching command transfer");

  assert property (@(posedge clk) disable iff (rst)
    (done && result.status != mqfm_pkg::ST_OK) |-> (result.item_out == 16'd0))
    else $error("failed step reports a nonzero item");

  assert property (@(posedge clk) disable iff (rst)
    (done && result.status == mqfm_pkg::ST_INVALID) |-> (result.queue_count == 5'd0))
    else $error("invalid queue reports a nonzero count");

  assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule

bind multi_queue_fifo_manager_core mqfm_checker u_mqfm_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

// ===== sim/tb_multi_queue_fifo_manager_core.sv =====
`timescale 1ns / 1ps

module tb_multi_queue_fifo_manager_core;

  localparam int NQ          = mqfm_pkg::NUM_QUEUES_DEF;
  localparam int DEPTH       = mqfm_pkg::QUEUE_DEPTH_DEF;
  localparam int IDLE_NONE   = 0;
  localparam int IDLE_LIGHT  = 8;
  localparam int IDLE_HEAVY  = 83;
  localparam int DRAIN_SLACK = 4;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int REPORT_MAX  = 10;
  localparam int BURST_LEN   = 40;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  mqfm_pkg::item_t   item = '0;
  logic              done;
  mqfm_pkg::result_t result;
  logic              cfg_write = 1'b0;
  logic [3:0]        cfg_data = 4'd0;

  multi_queue_fifo_manager_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the queue state, advanced once per accepted transfer.
  logic [15:0] ring_mem [NQ][DEPTH];
  logic [3:0]  ring_head [NQ];
  logic [4:0]  ring_count [NQ];
  logic [15:0] served_model;
  logic [7:0]  waiting_model;
  logic [3:0]  queues_model;

  mqfm_pkg::result_t pending_results [$];
  int                mismatch_count = 0;
  int                result_index = 0;
  int                cycle_count = 0;

  typedef struct {
    bit                is_cfg;
    logic [3:0]        cfg_value;
    mqfm_pkg::item_t   it;
    int                reps;
    bit                typed;
    mqfm_pkg::result_t want;
  } stim_row_t;

  stim_row_t stim_rows [$];

  function automatic mqfm_pkg::result_t queue_step(mqfm_pkg::item_t it);
    mqfm_pkg::result_t r;
    int                q;
    logic [3:0]        slot;
    r = '0;
    r.status = mqfm_pkg::ST_OK;
    q = it.queue_index;
    if (q >= queues_model || q >= NQ) begin
      r.status = mqfm_pkg::ST_INVALID;
    end else if (it.operation == mqfm_pkg::OP_ENQUEUE) begin
      if (ring_count[q] >= DEPTH) begin
        r.status = mqfm_pkg::ST_FULL;
      end else begin
        slot = 4'(ring_head[q] + ring_count[q]);
        ring_mem[q][slot] = it.item_id;
        ring_count[q] = ring_count[q] + 5'd1;
        waiting_model = waiting_model + 8'd1;
      end
      r.queue_count = ring_count[q];
    end else begin
      if (ring_count[q] == 0) begin
        r.status = mqfm_pkg::ST_EMPTY;
      end else begin
        r.item_out = ring_mem[q][ring_head[q]];
        ring_head[q] = ring_head[q] + 4'd1;
        ring_count[q] = ring_count[q] - 5'd1;
        waiting_model = waiting_model - 8'd1;
        if (served_model != mqfm_pkg::SERVED_MAX) served_model = served_model + 16'd1;
      end
      r.queue_count = ring_count[q];
    end
    r.served_total = served_model;
    r.waiting_total = waiting_model;
    return r;
  endfunction

  function automatic void add_op(mqfm_pkg::op_t op, int q, int id, int reps);
    stim_row_t row;
    row = '{is_cfg: 1'b0, cfg_value: 4'd0, it: mqfm_pkg::item_t'{op, 3'(q), 16'(id)},
            reps: reps, typed: 1'b0, want: '0};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_check(mqfm_pkg::op_t op, int q, int id,
                                    mqfm_pkg::result_t want);
    stim_row_t row;
    row = '{is_cfg: 1'b0, cfg_value: 4'd0, it: mqfm_pkg::item_t'{op, 3'(q), 16'(id)},
            reps: 1, typed: 1'b1, want: want};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_cfg(int value);
    stim_row_t row;
    row = '{is_cfg: 1'b1, cfg_value: 4'(value), it: '0, reps: 0, typed: 1'b0, want: '0};
    stim_rows.push_back(row);
  endfunction

  // Random traffic leans on one hot queue so that it runs full and empty in turn.
  function automatic mqfm_pkg::item_t random_item(int enq_pct, int hot_q);
    mqfm_pkg::item_t it;
    int              live;
    int              q;
    live = (queues_model > NQ) ? NQ : queues_model;
    if (live == 0 || (live < NQ && $urandom_range(99) < 10)) begin
      q = $urandom_range(NQ - 1, live);
    end else if (hot_q < live && $urandom_range(99) < 70) begin
      q = hot_q;
    end else begin
      q = $urandom_range(live - 1, 0);
    end
    it.operation = ($urandom_range(99) < enq_pct) ? mqfm_pkg::OP_ENQUEUE :
                                                     mqfm_pkg::OP_DEQUEUE;
    it.queue_index = 3'(q);
    case ($urandom_range(9))
      0: it.item_id = 16'h0000;
      1: it.item_id = 16'hFFFF;
      default: it.item_id = 16'($urandom);
    endcase
    return it;
  endfunction

  task automatic issue_item(mqfm_pkg::item_t it, int gap_pct, bit use_typed,
                            mqfm_pkg::result_t typed_want);
    mqfm_pkg::result_t predicted;
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    predicted = queue_step(it);
    pending_results.push_back(use_typed ? typed_want : predicted);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic set_queues_in_use(logic [3:0] value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    queues_model = value;
  endtask

  task automatic check_result(mqfm_pkg::result_t got);
    mqfm_pkg::result_t want;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("ERROR: result %0d arrived with none expected: %s",
                 result_index,
                 $sformatf("st=%0d id=%h cnt=%0d srv=%0d wait=%0d",
                           got.status, got.item_out, got.queue_count,
                           got.served_total, got.waiting_total));
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status || got.item_out !== want.item_out ||
          got.queue_count !== want.queue_count || got.served_total !== want.served_total ||
          got.waiting_total !== want.waiting_total) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("ERROR: result %0d expected st=%0d id=%h cnt=%0d srv=%0d wait=%0d",
                   result_index, want.status, want.item_out, want.queue_count,
                   want.served_total, want.waiting_total);
          $display("       got               st=%0d id=%h cnt=%0d srv=%0d wait=%0d",
                   got.status, got.item_out, got.queue_count,
                   got.served_total, got.waiting_total);
        end
      end
    end
    result_index++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else if (!rst && done) begin
      check_result(result);
    end
  end

  initial begin
    int phase_cfg [10];
    int phase_gap [4];
    int count;
    int hot_q;
    int enq_pct;

    foreach (ring_head[i]) begin
      ring_head[i] = '0;
      ring_count[i] = '0;
    end
    served_model = '0;
    waiting_model = '0;
    queues_model = mqfm_pkg::QUEUES_RESET;

    // Empty dequeues after reset, a short round trip, then one queue filled past full
    // and drained again across the wrap of its ring.
    add_check(mqfm_pkg::OP_DEQUEUE, 0, 16'h1111,
              mqfm_pkg::result_t'{mqfm_pkg::ST_EMPTY, 16'h0000, 5'd0, 16'd0, 8'd0});
    add_check(mqfm_pkg::OP_DEQUEUE, 7, 16'h2222,
              mqfm_pkg::result_t'{mqfm_pkg::ST_EMPTY, 16'h0000, 5'd0, 16'd0, 8'd0});
    add_check(mqfm_pkg::OP_ENQUEUE, 0, 16'hFFFF,
              mqfm_pkg::result_t'{mqfm_pkg::ST_OK, 16'h0000, 5'd1, 16'd0, 8'd1});
    add_check(mqfm_pkg::OP_ENQUEUE, 7, 16'h0000,
              mqfm_pkg::result_t'{mqfm_pkg::ST_OK, 16'h0000, 5'd1, 16'd0, 8'd2});
    add_check(mqfm_pkg::OP_ENQUEUE, 7, 16'hAAAA,
              mqfm_pkg::result_t'{mqfm_pkg::ST_OK, 16'h0000, 5'd2, 16'd0, 8'd3});
    add_check(mqfm_pkg::OP_DEQUEUE, 0, 16'h0000,
              mqfm_pkg::result_t'{mqfm_pkg::ST_OK, 16'hFFFF, 5'd0, 16'd1, 8'd2});
    add_check(mqfm_pkg::OP_DEQUEUE, 7, 16'h0000,
              mqfm_pkg::result_t'{mqfm_pkg::ST_OK, 16'h0000, 5'd1, 16'd2, 8'd1});
    add_check(mqfm_pkg::OP_DEQUEUE, 7, 16'h0000,
              mqfm_pkg::result_t'{mqfm_pkg::ST_OK, 16'hAAAA, 5'd0, 16'd3, 8'd0});
    add_op(mqfm_pkg::OP_ENQUEUE, 5, 16'h5555, DEPTH);
    add_check(mqfm_pkg::OP_ENQUEUE, 5, 16'h1234,
              mqfm_pkg::result_t'{mqfm_pkg::ST_FULL, 16'h0000, 5'd16, 16'd3, 8'd16});
    add_check(mqfm_pkg::OP_DEQUEUE, 5, 16'h0000,
              mqfm_pkg::result_t'{mqfm_pkg::ST_OK, 16'h5555, 5'd15, 16'd4, 8'd15});
    add_op(mqfm_pkg::OP_ENQUEUE, 5, 16'h8001, 1);
    add_op(mqfm_pkg::OP_DEQUEUE, 5, 16'h0000, DEPTH);
    add_check(mqfm_pkg::OP_DEQUEUE, 5, 16'h0000,
              mqfm_pkg::result_t'{mqfm_pkg::ST_EMPTY, 16'h0000, 5'd0, 16'd20, 8'd0});
    add_op(mqfm_pkg::OP_ENQUEUE, 2, 16'h8000, 1);
    add_op(mqfm_pkg::OP_ENQUEUE, 3, 16'h7FFF, 1);
    add_op(mqfm_pkg::OP_ENQUEUE, 4, 16'h0001, 1);
    // With no queues in use every index is rejected.
    add_cfg(0);
    add_check(mqfm_pkg::OP_ENQUEUE, 0, 16'hBEEF,
              mqfm_pkg::result_t'{mqfm_pkg::ST_INVALID, 16'h0000, 5'd0, 16'd20, 8'd3});
    add_check(mqfm_pkg::OP_DEQUEUE, 7, 16'h0000,
              mqfm_pkg::result_t'{mqfm_pkg::ST_INVALID, 16'h0000, 5'd0, 16'd20, 8'd3});
    // A setting above the queue count behaves as the full count.
    add_cfg(15);
    add_op(mqfm_pkg::OP_ENQUEUE, 7, 16'h4321, 1);
    add_cfg(1);
    add_check(mqfm_pkg::OP_DEQUEUE, 1, 16'h0000,
              mqfm_pkg::result_t'{mqfm_pkg::ST_INVALID, 16'h0000, 5'd0, 16'd20, 8'd4});
    add_check(mqfm_pkg::OP_DEQUEUE, 0, 16'h0000,
              mqfm_pkg::result_t'{mqfm_pkg::ST_EMPTY, 16'h0000, 5'd0, 16'd20, 8'd4});

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        drain_results();
        set_queues_in_use(stim_rows[i].cfg_value);
      end else begin
        repeat (stim_rows[i].reps)
          issue_item(stim_rows[i].it, IDLE_NONE, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    phase_cfg = '{8, 1, 15, 0, 3, 6, 11, 8, 2, 8};
    phase_cfg[5] = $urandom_range(7, 2);
    phase_cfg[6] = $urandom_range(14, 9);
    // The receiver cannot stall, so its stall phase runs without idling.
    phase_gap = '{IDLE_NONE, IDLE_HEAVY, IDLE_NONE, IDLE_LIGHT};

    foreach (phase_cfg[p]) begin
      drain_results();
      set_queues_in_use(4'(phase_cfg[p]));
      count = (phase_cfg[p] == 0) ? 40 : 150;
      hot_q = 0;
      enq_pct = 80;
      for (int n = 0; n < count; n++) begin
        if (n % BURST_LEN == 0) begin
          hot_q = $urandom_range(NQ - 1, 0);
          enq_pct = ((n / BURST_LEN) % 2 == 0) ? 80 : 20;
        end
        issue_item(random_item(enq_pct, hot_q), phase_gap[p % 4], 1'b0, '0);
      end
    end

    drain_results();
    mismatch_count += pending_results.size();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== multi_queue_fifo_manager_core.f =====
rtl/core/mqfm_pkg.sv
rtl/core/multi_queue_fifo_manager_core.sv
rtl/core/mqfm_checker.sv
sim/tb_multi_queue_fifo_manager_core.sv
